// ===== rtl/sbfi_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfi_pkg
// Types, constants and helpers shared by the segment/box face intersect block.
// ----------------------------------------------------------------------------
package sbfi_pkg;

    localparam int NUM_FACES = 6;
    localparam int NUM_AXES  = 3;
    localparam int QUO_BITS  = 33;                       // offset magnitude < 2^33
    localparam int DIV_STG   = (QUO_BITS + 1) / 2;       // up to two quotient bits a stage
    // input reg, distance stage, product stage, divider, point stage, select stage
    localparam int LATENCY   = 3 + DIV_STG + 2;

    typedef logic [31:0] coord_t;
    typedef logic [NUM_AXES-1:0][31:0] vec_t;

    typedef struct packed {
        vec_t s;
        vec_t e;
        vec_t lo;
        vec_t hi;
    } query_t;

    // one lane of the restoring divider
    typedef struct packed {
        logic [64:0] rem;
        logic [33:0] den;
        logic [32:0] quo;
        logic        neg;
    } lane_t;

    function automatic logic [1:0] face_axis(input int f);
        return 2'(f % NUM_AXES);
    endfunction

    // off-plane axis handled by divider lane m of face f
    function automatic logic [1:0] lane_axis(input int f, input int m);
        return 2'((f + 1 + m) % NUM_AXES);
    endfunction

    function automatic lane_t div_step(input lane_t l, input int i);
        logic [65:0] dsh;
        logic [65:0] r;
        lane_t       o;
        o   = l;
        dsh = {32'd0, l.den} << i;
        r   = {1'b0, l.rem};
        if (r >= dsh)
        begin
            o.rem         = l.rem - dsh[64:0];
            o.quo[i[5:0]] = 1'b1;
        end
        return o;
    endfunction

endpackage

// ===== rtl/segment_box_face_intersect_top.sv =====
// ----------------------------------------------------------------------------
// segment_box_face_intersect_top
// Line segment versus axis-aligned box face test, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | handshake            | fields
//  ---------+----------------------+-----------------------------------------
//  request  | start / busy         | start_xyz, end_xyz, box_min_xyz, box_max_xyz
//  result   | done (1-cycle pulse) | hit_found, hit_face, hit_x, hit_y, hit_z
//
//  One request per cycle; busy is always low. The result is registered through the
//  input, distance and product stages, the 17-stage divider (up to 2 quotient bits
//  a stage) and the point and select stages.
//  Reset clears the valid bits only; results cannot be stalled.
// ----------------------------------------------------------------------------
module segment_box_face_intersect_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sbfi_pkg::coord_t     start_x,
    input  sbfi_pkg::coord_t     start_y,
    input  sbfi_pkg::coord_t     start_z,
    input  sbfi_pkg::coord_t     end_x,
    input  sbfi_pkg::coord_t     end_y,
    input  sbfi_pkg::coord_t     end_z,
    input  sbfi_pkg::coord_t     box_min_x,
    input  sbfi_pkg::coord_t     box_min_y,
    input  sbfi_pkg::coord_t     box_min_z,
    input  sbfi_pkg::coord_t     box_max_x,
    input  sbfi_pkg::coord_t     box_max_y,
    input  sbfi_pkg::coord_t     box_max_z,
    output logic                 done,
    output logic                 hit_found,
    output logic [2:0]           hit_face,
    output sbfi_pkg::coord_t     hit_x,
    output sbfi_pkg::coord_t     hit_y,
    output sbfi_pkg::coord_t     hit_z
);
    import sbfi_pkg::*;

    // valid bits: 0 input, 1 distance, 2 product, 3..2+DIV_STG divider, then point, out
    localparam int NVLD = LATENCY;

    logic [NVLD-1:0] vld_reg;

    // stage A: captured request
    query_t q_a_reg;

    // stage B: plane distances
    query_t                          q_b_reg;
    logic [NUM_FACES-1:0]            cross_b_reg, cross_b_next;
    logic [NUM_FACES-1:0][32:0]      a_b_reg, a_b_next;
    logic [NUM_FACES-1:0][33:0]      den_b_reg, den_b_next;
    logic [NUM_AXES-1:0][32:0]       dmag_b_reg, dmag_b_next;
    logic [NUM_AXES-1:0]             dneg_b_reg, dneg_b_next;

    // divider pipeline, index 0 holds the products
    query_t               q_d_reg     [0:DIV_STG];
    logic [NUM_FACES-1:0] cross_d_reg [0:DIV_STG];
    lane_t                lane_reg    [0:DIV_STG][0:NUM_FACES-1][0:1];
    lane_t                lane_next   [0:DIV_STG][0:NUM_FACES-1][0:1];

    // stage E: candidate points per face
    logic [NUM_FACES-1:0]       hit_e_reg, hit_e_next;
    vec_t [NUM_FACES-1:0]       pt_e_reg, pt_e_next;

    // output registers
    logic        found_reg, found_next;
    logic [2:0]  face_reg, face_next;
    vec_t        res_reg, res_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NVLD-2:0], start & ~busy};
    end

    always_ff @(posedge clk)
    begin
        q_a_reg.s  <= {start_z, start_y, start_x};
        q_a_reg.e  <= {end_z, end_y, end_x};
        q_a_reg.lo <= {box_min_z, box_min_y, box_min_x};
        q_a_reg.hi <= {box_max_z, box_max_y, box_max_x};
    end

    // distances of the endpoints to each face plane
    always_comb
    begin
        logic [1:0]  ax;
        logic [31:0] b;
        logic [32:0] d1, d2, m2, dl;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            ax = face_axis(f);
            b  = (f < NUM_AXES) ? q_a_reg.lo[ax] : q_a_reg.hi[ax];
            d1 = {q_a_reg.s[ax][31], q_a_reg.s[ax]} - {b[31], b};
            d2 = {q_a_reg.e[ax][31], q_a_reg.e[ax]} - {b[31], b};
            cross_b_next[f] = (d1[32] && !d2[32] && (d2 != '0)) ||
                              (!d1[32] && (d1 != '0) && d2[32]);
            a_b_next[f]   = d1[32] ? -d1 : d1;
            m2            = d2[32] ? -d2 : d2;
            den_b_next[f] = {1'b0, a_b_next[f]} + {1'b0, m2};
        end
        for (int k = 0; k < NUM_AXES; k++)
        begin
            dl = {q_a_reg.e[k][31], q_a_reg.e[k]} - {q_a_reg.s[k][31], q_a_reg.s[k]};
            dneg_b_next[k] = dl[32];
            dmag_b_next[k] = dl[32] ? -dl : dl;
        end
    end

    always_ff @(posedge clk)
    begin
        q_b_reg     <= q_a_reg;
        cross_b_reg <= cross_b_next;
        a_b_reg     <= a_b_next;
        den_b_reg   <= den_b_next;
        dmag_b_reg  <= dmag_b_next;
        dneg_b_reg  <= dneg_b_next;
    end

    // products |delta| * a, then up to two quotient bits per stage
    always_comb
    begin
        logic [1:0]  j;
        logic [65:0] prod;
        lane_t       t;
        for (int f = 0; f < NUM_FACES; f++)
        begin
            for (int m = 0; m < 2; m++)
            begin
                j    = lane_axis(f, m);
                prod = dmag_b_reg[j] * a_b_reg[f];
                lane_next[0][f][m].rem = prod[64:0];
                lane_next[0][f][m].den = den_b_reg[f];
                lane_next[0][f][m].quo = '0;
                lane_next[0][f][m].neg = dneg_b_reg[j];
                for (int g = 0; g < DIV_STG; g++)
                begin
                    t = div_step(lane_reg[g][f][m], QUO_BITS - 1 - 2 * g);
                    if (QUO_BITS - 2 - 2 * g >= 0)
                        t = div_step(t, QUO_BITS - 2 - 2 * g);
                    lane_next[g+1][f][m] = t;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_d_reg[0]     <= q_b_reg;
        cross_d_reg[0] <= cross_b_reg;
        for (int g = 0; g < DIV_STG; g++)
        begin
            q_d_reg[g+1]     <= q_d_reg[g];
            cross_d_reg[g+1] <= cross_d_reg[g];
        end
        for (int g = 0; g <= DIV_STG; g++)
            for (int f = 0; f < NUM_FACES; f++)
                for (int m = 0; m < 2; m++)
                    lane_reg[g][f][m] <= lane_next[g][f][m];
    end

    // crossing points and strict bounds test
    always_comb
    begin
        logic [1:0]  ax, j;
        logic [33:0] off, sum;
        logic [31:0] p;
        logic        ins;
        lane_t       l;
        query_t      q;
        q = q_d_reg[DIV_STG];
        for (int f = 0; f < NUM_FACES; f++)
        begin
            ax  = face_axis(f);
            ins = cross_d_reg[DIV_STG][f];
            pt_e_next[f] = '0;
            pt_e_next[f][ax] = (f < NUM_AXES) ? q.lo[ax] : q.hi[ax];
            for (int m = 0; m < 2; m++)
            begin
                j   = lane_axis(f, m);
                l   = lane_reg[DIV_STG][f][m];
                off = l.neg ? -{1'b0, l.quo} : {1'b0, l.quo};
                sum = {{2{q.s[j][31]}}, q.s[j]} + off;
                if ((sum[33] != sum[31]) || (sum[32] != sum[31]))
                    p = sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                else
                    p = sum[31:0];
                pt_e_next[f][j] = p;
                if (!(($signed(p) > $signed(q.lo[j])) && ($signed(p) < $signed(q.hi[j]))))
                    ins = 1'b0;
            end
            hit_e_next[f] = ins;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_e_reg <= hit_e_next;
        pt_e_reg  <= pt_e_next;
    end

    // lowest numbered face wins
    always_comb
    begin
        found_next = 1'b0;
        face_next  = '0;
        res_next   = '0;
        for (int f = NUM_FACES - 1; f >= 0; f--)
        begin
            if (hit_e_reg[f])
            begin
                found_next = 1'b1;
                face_next  = 3'(f);
                res_next   = pt_e_reg[f];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        face_reg  <= face_next;
        res_reg   <= res_next;
    end

    assign done      = vld_reg[NVLD-1];
    assign hit_found = found_reg;
    assign hit_face  = face_reg;
    assign hit_x     = res_reg[0];
    assign hit_y     = res_reg[1];
    assign hit_z     = res_reg[2];

endmodule

// ===== rtl/sbfi_checker.sv =====
// ----------------------------------------------------------------------------
// sbfi_checker
// Port-level checks for segment_box_face_intersect_top.
// ----------------------------------------------------------------------------
module sbfi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        hit_found,
    input logic [2:0]  hit_face,
    input logic [31:0] hit_x,
    input logic [31:0] hit_y,
    input logic [31:0] hit_z
);
    import sbfi_pkg::*;

    // every result answers a request that the pipeline accepted earlier
    a_done_matches_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching request");

    a_request_gets_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && !busy, LATENCY) && $past(rst_n, LATENCY) |-> done)
        else $error("request lost");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit_found |-> (hit_face == 3'd0) && (hit_x == '0) &&
                               (hit_y == '0) && (hit_z == '0))
        else $error("miss result not cleared");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit_found |-> (hit_face <= 3'd5))
        else $error("face code out of range");

endmodule

bind segment_box_face_intersect_top sbfi_checker u_sbfi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .hit_found (hit_found),
    .hit_face  (hit_face),
    .hit_x     (hit_x),
    .hit_y     (hit_y),
    .hit_z     (hit_z)
);

// ===== dv/segment_box_face_intersect_checker.sv =====
// ----------------------------------------------------------------------------
// segment_box_face_intersect_checker
// Watches the request and result ports, computes the expected face hit for
// each accepted request and compares every result field against it.
// ----------------------------------------------------------------------------
module segment_box_face_intersect_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  sbfi_pkg::coord_t start_x,
    input  sbfi_pkg::coord_t start_y,
    input  sbfi_pkg::coord_t start_z,
    input  sbfi_pkg::coord_t end_x,
    input  sbfi_pkg::coord_t end_y,
    input  sbfi_pkg::coord_t end_z,
    input  sbfi_pkg::coord_t box_min_x,
    input  sbfi_pkg::coord_t box_min_y,
    input  sbfi_pkg::coord_t box_min_z,
    input  sbfi_pkg::coord_t box_max_x,
    input  sbfi_pkg::coord_t box_max_y,
    input  sbfi_pkg::coord_t box_max_z,
    input  logic             done,
    input  logic             hit_found,
    input  logic [2:0]       hit_face,
    input  sbfi_pkg::coord_t hit_x,
    input  sbfi_pkg::coord_t hit_y,
    input  sbfi_pkg::coord_t hit_z,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       found;
        logic [2:0] face;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } hit_t;

    hit_t expected_hits[$];

    assign pending = expected_hits.size();

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic hit_t first_face_hit(input longint s[3], input longint e[3],
                                            input longint lo[3], input longint hi[3]);
        hit_t   h;
        longint p[3];
        longint plane, d1, d2, delta, mag_d;
        longint unsigned num, den, q;
        int     ax;
        logic   in_box;
        h = '{1'b0, 3'd0, 32'd0, 32'd0, 32'd0};
        for (int f = 0; f < sbfi_pkg::NUM_FACES; f++)
        begin
            if (h.found)
                break;
            ax    = f % 3;
            plane = (f < 3) ? lo[ax] : hi[ax];
            d1    = s[ax] - plane;
            d2    = e[ax] - plane;
            if (!((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)))
                continue;
            num = (d1 < 0) ? -d1 : d1;
            den = num + ((d2 < 0) ? -d2 : d2);
            for (int j = 0; j < 3; j++)
            begin
                delta = e[j] - s[j];
                mag_d = (delta < 0) ? -delta : delta;
                // num * |delta| can exceed 64 bits
                q    = 64'(({64'd0, 64'(mag_d)} * {64'd0, num}) / {64'd0, den});
                p[j] = clamp32(s[j] + ((delta < 0) ? -longint'(q) : longint'(q)));
            end
            in_box = 1'b1;
            for (int j = 0; j < 3; j++)
                if (j != ax && !(p[j] > lo[j] && p[j] < hi[j]))
                    in_box = 1'b0;
            if (in_box)
            begin
                h.found = 1'b1;
                h.face  = 3'(f);
                h.x     = 32'(p[0]);
                h.y     = 32'(p[1]);
                h.z     = 32'(p[2]);
            end
        end
        return h;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk)
    begin
        longint s[3], e[3], lo[3], hi[3];
        hit_t   want;
        if (rst_n && start && !busy)
        begin
            s  = '{longint'(signed'(start_x)), longint'(signed'(start_y)),
                   longint'(signed'(start_z))};
            e  = '{longint'(signed'(end_x)), longint'(signed'(end_y)),
                   longint'(signed'(end_z))};
            lo = '{longint'(signed'(box_min_x)), longint'(signed'(box_min_y)),
                   longint'(signed'(box_min_z))};
            hi = '{longint'(signed'(box_max_x)), longint'(signed'(box_max_y)),
                   longint'(signed'(box_max_z))};
            expected_hits = {expected_hits, first_face_hit(s, e, lo, hi)};
        end
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (hit_found !== want.found)
                    report_mismatch("hit_found", 32'(hit_found), 32'(want.found));
                if (hit_face !== want.face)
                    report_mismatch("hit_face", 32'(hit_face), 32'(want.face));
                if (hit_x !== want.x)
                    report_mismatch("hit_x", hit_x, want.x);
                if (hit_y !== want.y)
                    report_mismatch("hit_y", hit_y, want.y);
                if (hit_z !== want.z)
                    report_mismatch("hit_z", hit_z, want.z);
            end
        end
    end

endmodule

// ===== dv/segment_box_face_intersect_top_tb.sv =====
// ----------------------------------------------------------------------------
// segment_box_face_intersect_top_tb
// Drives directed and random segment/box queries with random request gaps;
// the checker predicts each face hit and compares the results.
// ----------------------------------------------------------------------------
module segment_box_face_intersect_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1500;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    sbfi_pkg::coord_t start_x, start_y, start_z, end_x, end_y, end_z;
    sbfi_pkg::coord_t box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z;
    logic             done;
    logic             hit_found;
    logic [2:0]       hit_face;
    sbfi_pkg::coord_t hit_x, hit_y, hit_z;
    int               fail_count;
    int               pending;

    segment_box_face_intersect_top dut (.*);
    segment_box_face_intersect_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("[segment_box_face_intersect_top] ERROR");
        $finish;
    end

    // holds one request on the ports until accepted
    task automatic send_query(input logic [31:0] q[12]);
        start     <= 1'b1;
        start_x   <= q[0];  start_y   <= q[1];  start_z   <= q[2];
        end_x     <= q[3];  end_y     <= q[4];  end_z     <= q[5];
        box_min_x <= q[6];  box_min_y <= q[7];  box_min_z <= q[8];
        box_max_x <= q[9];  box_max_y <= q[10]; box_max_z <= q[11];
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic maybe_gap(input bit allow);
        int n;
        if (allow && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_coord(input int range_sel);
        case (range_sel)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            2: return $urandom_range(0, 1) ? 32'h7fff_fff0 + $urandom_range(0, 15)
                                            : 32'h8000_0000 + $urandom_range(0, 15);
            default: return 32'($signed($urandom_range(0, 200)) - 100) << 16;
        endcase
    endfunction

    // box around the origin-ish region; segment often spans it
    task automatic random_query(output logic [31:0] q[12]);
        int sel;
        logic [31:0] a, b;
        sel = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++)
        begin
            q[k]     = rand_coord(sel == 0 ? 0 : (sel == 1 ? 2 : (sel < 5 ? 3 : 1)));
            q[3 + k] = rand_coord(sel == 0 ? 0 : (sel == 1 ? 2 : (sel < 5 ? 3 : 1)));
            a = rand_coord(sel == 0 ? 0 : (sel == 1 ? 2 : 3));
            b = rand_coord(sel == 0 ? 0 : (sel == 1 ? 2 : 3));
            // mostly well-formed boxes, occasionally inverted
            if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b))
            begin
                q[6 + k] = b; q[9 + k] = a;
            end
            else
            begin
                q[6 + k] = a; q[9 + k] = b;
            end
        end
        // sometimes put an endpoint exactly on a face plane
        if ($urandom_range(0, 9) == 0)
            q[$urandom_range(0, 5)] = q[6 + $urandom_range(0, 5)];
    endtask

    initial
    begin
        logic [31:0] q[12];
        logic [31:0] one;
        logic [31:0] mx, mn;
        int          idle;
        one = 32'h0001_0000;
        mx  = 32'h7fff_ffff;
        mn  = 32'h8000_0000;
        rst_n = 1'b0;
        start = 1'b0;
        {start_x, start_y, start_z, end_x, end_y, end_z} = '0;
        {box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z} = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each face hit along its axis, box [-1,1]^3
        for (int f = 0; f < 6; f++)
        begin
            q = '{0, 0, 0, 0, 0, 0, -one, -one, -one, one, one, one};
            q[f % 3]     = (f < 3) ? -(one << 1) : (one << 1);
            q[3 + f % 3] = 0;
            send_query(q);
        end
        // degenerate segment
        q = '{0, 0, 0, 0, 0, 0, -one, -one, -one, one, one, one};
        send_query(q);
        // endpoint on plane
        q = '{-one, 0, 0, one << 1, 0, 0, -one, -one, -one, one, one, one};
        send_query(q);
        // edge hit: crossing lands on y bound
        q = '{-(one << 1), one, 0, 0, one, 0, -one, -one, -one, one, one, one};
        send_query(q);
        // inverted box
        q = '{-(one << 1), 0, 0, one << 1, 0, 0, one, one, one, -one, -one, -one};
        send_query(q);
        // full-range extremes
        q = '{mn, mn, mn, mx, mx, mx, mn, mn, mn, mx, mx, mx};
        send_query(q);
        q = '{mn, 0, 0, mx, 0, 0, -1, mn, mn, 1, mx, mx};
        send_query(q);
        q = '{mx, mx, mn, mn, mn, mx, 0, 0, 0, 1, 1, 1};
        send_query(q);
        q = '{32'hffff_ffff, 0, 0, 1, 0, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 2, 1, 1};
        send_query(q);
        q = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
              32'h5555_5555, 32'haaaa_aaaa, mn, mn, mn, mx, mx, mx};
        send_query(q);
        start <= 1'b0;

        // let the pipe drain completely once
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            random_query(q);
            send_query(q);
            maybe_gap(i < N_RANDOM - 200);
        end
        start <= 1'b0;

        idle = 0;
        while (pending != 0 && idle < 1000)
        begin
            @(posedge clk);
            idle++;
        end
        repeat (sbfi_pkg::LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[segment_box_face_intersect_top] OK");
        else
            $display("[segment_box_face_intersect_top] ERROR");
        $finish;
    end

endmodule
